// ===== design/cbc_pkg.sv =====
`timescale 1ns / 1ps

package cbc_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 1024;

    localparam int COL_W     = $clog2(MAX_WIDTH);
    localparam int ROW_W     = $clog2(MAX_HEIGHT);
    localparam int RUN_W     = $clog2(MAX_WIDTH + 1);
    localparam int COUNT_CAP = MAX_WIDTH * MAX_HEIGHT;
    localparam int COUNT_W   = $clog2(COUNT_CAP + 1);
    localparam int MOMENT_W  = 30;

    localparam int FLOOR_W = 8;
    localparam int GAIN_W  = 4;
    localparam int AREA_W  = 21;
    localparam int RATIO_W = 20;
    localparam int CX_W    = 10;
    localparam int WIDTH_W = 11;
    localparam int PIX_W   = 8;

    localparam int DIVIDEND_W = MOMENT_W;
    localparam int DIVISOR_W  = COUNT_W;
    localparam int DIV_STEPS  = DIVIDEND_W;
    localparam int STEP_W     = $clog2(DIV_STEPS);

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    localparam int TDATA_IN_W  = 24;
    localparam int TDATA_OUT_W = 80;
    localparam int APB_ADDR_W  = 5;
    localparam int APB_DATA_W  = 32;
    localparam int REG_IDX_W   = 3;

    localparam logic [REG_IDX_W-1:0] REG_GREEN_FLOOR    = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_GREEN_GAIN     = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_RED_BLUE_GAIN  = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_MIN_BLOB_AREA  = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_DISTANCE_RATIO = 3'd4;

    localparam logic [FLOOR_W-1:0] GREEN_FLOOR_RESET    = 8'd128;
    localparam logic [GAIN_W-1:0]  GREEN_GAIN_RESET     = 4'd4;
    localparam logic [GAIN_W-1:0]  RED_BLUE_GAIN_RESET  = 4'd3;
    localparam logic [AREA_W-1:0]  MIN_BLOB_AREA_RESET  = 21'd1000;
    localparam logic [RATIO_W-1:0] DISTANCE_RATIO_RESET = 20'd41489;

    typedef struct packed {
        logic [FLOOR_W-1:0] green_floor;
        logic [GAIN_W-1:0]  green_gain;
        logic [GAIN_W-1:0]  red_blue_gain;
        logic [AREA_W-1:0]  min_blob_area;
        logic [RATIO_W-1:0] distance_ratio;
    } cfg_t;

    typedef struct packed {
        logic                mask;
        logic                frame_end;
        logic [COUNT_W-1:0]  count;
        logic [MOMENT_W-1:0] x_moment;
        logic [MOMENT_W-1:0] y_moment;
        logic [RUN_W-1:0]    longest;
    } item_t;

endpackage

// ===== design/cbc_div.sv =====
`timescale 1ns / 1ps

module cbc_div
    import cbc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [DIVIDEND_W-1:0] dividend,
    input  logic [DIVISOR_W-1:0]  divisor,
    output logic                  busy,
    output logic [DIVIDEND_W-1:0] quotient
);

    logic                  busy_reg;
    logic [STEP_W-1:0]     step_reg;
    logic [DIVISOR_W-1:0]  rem_reg;
    logic [DIVISOR_W-1:0]  divisor_reg;
    logic [DIVIDEND_W-1:0] quo_reg;

    logic [DIVISOR_W:0]    shifted;
    logic [DIVISOR_W:0]    diff;
    logic                  fits;
    logic [DIVISOR_W-1:0]  rem_next;

    assign shifted  = {rem_reg, quo_reg[DIVIDEND_W-1]};
    assign diff     = shifted - {1'b0, divisor_reg};
    assign fits     = shifted >= {1'b0, divisor_reg};
    assign rem_next = fits ? diff[DIVISOR_W-1:0] : shifted[DIVISOR_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            step_reg <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            step_reg <= '0;
        end
        else if (busy_reg)
        begin
            step_reg <= step_reg + 1'b1;
            if (step_reg == STEP_W'(DIV_STEPS - 1))
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg     <= '0;
            quo_reg     <= dividend;
            divisor_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            quo_reg <= {quo_reg[DIVIDEND_W-2:0], fits};
        end
    end

    assign busy     = busy_reg;
    assign quotient = quo_reg;

endmodule

// ===== design/cbc_front.sv =====
`timescale 1ns / 1ps

module cbc_front
    import cbc_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  cfg_t             cfg,
    input  logic             accept,
    input  logic [PIX_W-1:0] red,
    input  logic [PIX_W-1:0] green,
    input  logic [PIX_W-1:0] blue,
    input  logic             line_end,
    input  logic             frame_end,
    output item_t            item
);

    logic [COL_W-1:0]    column_reg,   column_next;
    logic [ROW_W-1:0]    row_reg,      row_next;
    logic [COUNT_W-1:0]  count_reg,    count_next;
    logic [MOMENT_W-1:0] x_moment_reg, x_moment_next;
    logic [MOMENT_W-1:0] y_moment_reg, y_moment_next;
    logic [RUN_W-1:0]    run_reg,      run_next;
    logic [RUN_W-1:0]    longest_reg,  longest_next;

    logic [PIX_W+GAIN_W-1:0] green_prod;
    logic [PIX_W:0]          rb_sum;
    logic [PIX_W+GAIN_W:0]   rb_prod;
    logic                    mark;
    logic                    count_add;
    logic [COUNT_W-1:0]      count_upd;
    logic [MOMENT_W-1:0]     x_upd;
    logic [MOMENT_W-1:0]     y_upd;
    logic [RUN_W-1:0]        run_upd;
    logic [RUN_W-1:0]        longest_upd;

    always_comb
    begin
        green_prod  = cfg.green_gain * green;
        rb_sum      = {1'b0, red} + {1'b0, blue};
        rb_prod     = cfg.red_blue_gain * rb_sum;
        mark        = ({1'b0, green_prod} > rb_prod) && (green > cfg.green_floor);
        count_add   = mark && (count_reg != COUNT_W'(COUNT_CAP));
        count_upd   = count_add ? count_reg + 1'b1 : count_reg;
        x_upd       = count_add ? x_moment_reg + MOMENT_W'(column_reg) : x_moment_reg;
        y_upd       = count_add ? y_moment_reg + MOMENT_W'(row_reg) : y_moment_reg;
        if (!mark)
        begin
            run_upd = '0;
        end
        else if (run_reg < RUN_W'(MAX_WIDTH))
        begin
            run_upd = run_reg + 1'b1;
        end
        else
        begin
            run_upd = run_reg;
        end
        longest_upd = (mark && (run_upd > longest_reg)) ? run_upd : longest_reg;

        item.mask      = mark;
        item.frame_end = frame_end;
        item.count     = count_upd;
        item.x_moment  = x_upd;
        item.y_moment  = y_upd;
        item.longest   = longest_upd;

        column_next   = column_reg;
        row_next      = row_reg;
        count_next    = count_reg;
        x_moment_next = x_moment_reg;
        y_moment_next = y_moment_reg;
        run_next      = run_reg;
        longest_next  = longest_reg;
        if (accept)
        begin
            if (frame_end)
            begin
                column_next   = '0;
                row_next      = '0;
                count_next    = '0;
                x_moment_next = '0;
                y_moment_next = '0;
                run_next      = '0;
                longest_next  = '0;
            end
            else
            begin
                count_next    = count_upd;
                x_moment_next = x_upd;
                y_moment_next = y_upd;
                longest_next  = longest_upd;
                if (line_end)
                begin
                    column_next = '0;
                    run_next    = '0;
                    if (row_reg != ROW_W'(MAX_HEIGHT - 1))
                    begin
                        row_next = row_reg + 1'b1;
                    end
                end
                else
                begin
                    run_next = run_upd;
                    if (column_reg != COL_W'(MAX_WIDTH - 1))
                    begin
                        column_next = column_reg + 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            column_reg   <= '0;
            row_reg      <= '0;
            count_reg    <= '0;
            x_moment_reg <= '0;
            y_moment_reg <= '0;
            run_reg      <= '0;
            longest_reg  <= '0;
        end
        else
        begin
            column_reg   <= column_next;
            row_reg      <= row_next;
            count_reg    <= count_next;
            x_moment_reg <= x_moment_next;
            y_moment_reg <= y_moment_next;
            run_reg      <= run_next;
            longest_reg  <= longest_next;
        end
    end

endmodule

// ===== design/cbc_queue.sv =====
`timescale 1ns / 1ps

module cbc_queue
    import cbc_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push,
    input  item_t push_item,
    input  logic  pop,
    output item_t head,
    output logic  full,
    output logic  empty
);

    item_t               entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg;
    logic [QPTR_W-1:0]   rd_ptr_reg;
    logic [QPTR_W:0]     fill_reg;

    assign full  = fill_reg == (QPTR_W + 1)'(QUEUE_DEPTH);
    assign empty = fill_reg == '0;
    assign head  = entry_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                fill_reg <= fill_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                fill_reg <= fill_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

// ===== design/cbc_back.sv =====
`timescale 1ns / 1ps

module cbc_back
    import cbc_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  cfg_t                   cfg,
    input  item_t                  head,
    input  logic                   empty,
    output logic                   pop,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [TDATA_OUT_W-1:0] m_tdata,
    output logic                   m_tlast
);

    typedef enum logic [0:0] {
        ST_READY,
        ST_DIVIDE
    } state_t;

    state_t              state_reg;
    logic                valid_reg;
    logic                last_reg;
    logic                mask_reg;
    logic                found_reg;
    logic [CX_W-1:0]     cx_reg;
    logic [CX_W-1:0]     cy_reg;
    logic [WIDTH_W-1:0]  width_reg;
    logic [AREA_W-1:0]   area_reg;
    logic [RATIO_W-1:0]  dist_reg;
    item_t               hold_reg;

    logic                  out_free;
    logic                  start;
    logic                  busy_x, busy_y, busy_d;
    logic [DIVIDEND_W-1:0] quo_x, quo_y, quo_d;
    logic                  found;
    logic                  load_pixel;
    logic                  load_summary;

    assign out_free     = !valid_reg || m_tready;
    assign pop          = (state_reg == ST_READY) && !empty && out_free;
    assign start        = pop && head.frame_end;
    assign found        = hold_reg.count > cfg.min_blob_area;
    assign load_pixel   = pop && !head.frame_end;
    assign load_summary = (state_reg == ST_DIVIDE) && !busy_x && !busy_y && !busy_d
                          && out_free;

    cbc_div u_div_x (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .dividend (head.x_moment),
        .divisor  (head.count),
        .busy     (busy_x),
        .quotient (quo_x)
    );

    cbc_div u_div_y (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .dividend (head.y_moment),
        .divisor  (head.count),
        .busy     (busy_y),
        .quotient (quo_y)
    );

    cbc_div u_div_d (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .dividend (DIVIDEND_W'(cfg.distance_ratio)),
        .divisor  (DIVISOR_W'(head.longest)),
        .busy     (busy_d),
        .quotient (quo_d)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_READY;
            valid_reg <= 1'b0;
            last_reg  <= 1'b0;
            mask_reg  <= 1'b0;
            found_reg <= 1'b0;
            cx_reg    <= '0;
            cy_reg    <= '0;
            width_reg <= '0;
            area_reg  <= '0;
            dist_reg  <= '0;
            hold_reg  <= '0;
        end
        else
        begin
            if (load_pixel || load_summary)
            begin
                valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_READY:
                begin
                    if (pop)
                    begin
                        if (head.frame_end)
                        begin
                            hold_reg  <= head;
                            state_reg <= ST_DIVIDE;
                        end
                        else
                        begin
                            last_reg  <= 1'b0;
                            mask_reg  <= head.mask;
                            found_reg <= 1'b0;
                            cx_reg    <= '0;
                            cy_reg    <= '0;
                            width_reg <= '0;
                            area_reg  <= '0;
                            dist_reg  <= '0;
                        end
                    end
                end
                ST_DIVIDE:
                begin
                    if (load_summary)
                    begin
                        last_reg  <= 1'b1;
                        mask_reg  <= hold_reg.mask;
                        found_reg <= found;
                        cx_reg    <= found ? quo_x[CX_W-1:0] : '0;
                        cy_reg    <= found ? quo_y[CX_W-1:0] : '0;
                        width_reg <= WIDTH_W'(hold_reg.longest);
                        area_reg  <= AREA_W'(hold_reg.count);
                        dist_reg  <= (found && hold_reg.longest != '0) ?
                                     quo_d[RATIO_W-1:0] : '0;
                        state_reg <= ST_READY;
                    end
                end
                default:
                begin
                    state_reg <= ST_READY;
                end
            endcase
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tlast  = last_reg;
    assign m_tdata  = {6'b0, dist_reg, area_reg, width_reg, cy_reg, cx_reg,
                       found_reg, mask_reg};

`ifndef SYNTHESIS
    a_found_area: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && found_reg) |-> (area_reg > cfg.min_blob_area))
        else $error("found reported with area at or below minimum");

    a_summary_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && !last_reg) |-> (!found_reg && cx_reg == '0 && cy_reg == '0
        && width_reg == '0 && area_reg == '0 && dist_reg == '0))
        else $error("summary fields set on a non-final pixel");

    a_no_pop_divide: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIVIDE) |-> !pop)
        else $error("queue popped during frame division");

    a_div_start: assert property (@(posedge clk) disable iff (!rst_n)
        start |=> (busy_x && busy_y && busy_d && state_reg == ST_DIVIDE))
        else $error("dividers not running after frame end");
`endif

endmodule

// ===== design/color_blob_centroid_core.sv =====
`timescale 1ns / 1ps

// Green blob detector over a raster pixel stream.
// Input stream s_*: one pixel per transaction; s_tdata = {blue, green, red},
// s_tuser marks the last pixel of a row, s_tlast the last pixel of a frame.
// Output stream m_*: one result per pixel, in order; m_tlast marks the frame
// summary, which rides on the result of the frame's last pixel.
// A pixel's result passes through the queue and then the output register;
// the frame summary is loaded once the bit-serial dividers in the back
// part are done (one quotient bit per cycle, 30 bits).
// Throughput: one pixel per cycle while s_tready is high; at frame end the
// front keeps accepting until its 4-entry queue fills, then stalls until the
// summary is out. A receiver stall holds the output register; the queue
// absorbs up to four pixels before s_tready drops.
// Reset clears all frame state, the queue and the output register, and loads
// the register defaults. Registers sit on the APB port at 4*index; write
// them only while the stream is idle.

module color_blob_centroid_core
    import cbc_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [APB_ADDR_W-1:0]  paddr,
    input  logic [APB_DATA_W-1:0]  pwdata,
    output logic [APB_DATA_W-1:0]  prdata,
    output logic                   pready,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [TDATA_IN_W-1:0]  s_tdata,   // red[7:0], green[15:8], blue[23:16]
    input  logic                   s_tuser,   // line_end
    input  logic                   s_tlast,   // frame_end
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // mask[0], found[1], centre_x[11:2], centre_y[21:12], blob_width[32:22],
    // blob_area[53:33], distance[73:54], zero[79:74]
    output logic [TDATA_OUT_W-1:0] m_tdata,
    output logic                   m_tlast    // frame_done
);

    cfg_t                 cfg_reg;
    logic                 cfg_write;
    logic [REG_IDX_W-1:0] reg_idx;
    logic                 accept;
    logic                 q_full;
    logic                 q_empty;
    logic                 q_pop;
    item_t                push_item;
    item_t                head;

    assign pready    = 1'b1;
    assign reg_idx   = paddr[APB_ADDR_W-1:2];
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.green_floor    <= GREEN_FLOOR_RESET;
            cfg_reg.green_gain     <= GREEN_GAIN_RESET;
            cfg_reg.red_blue_gain  <= RED_BLUE_GAIN_RESET;
            cfg_reg.min_blob_area  <= MIN_BLOB_AREA_RESET;
            cfg_reg.distance_ratio <= DISTANCE_RATIO_RESET;
        end
        else if (cfg_write)
        begin
            case (reg_idx)
                REG_GREEN_FLOOR:    cfg_reg.green_floor    <= pwdata[FLOOR_W-1:0];
                REG_GREEN_GAIN:     cfg_reg.green_gain     <= pwdata[GAIN_W-1:0];
                REG_RED_BLUE_GAIN:  cfg_reg.red_blue_gain  <= pwdata[GAIN_W-1:0];
                REG_MIN_BLOB_AREA:  cfg_reg.min_blob_area  <= pwdata[AREA_W-1:0];
                REG_DISTANCE_RATIO: cfg_reg.distance_ratio <= pwdata[RATIO_W-1:0];
                default:            ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            REG_GREEN_FLOOR:    prdata = APB_DATA_W'(cfg_reg.green_floor);
            REG_GREEN_GAIN:     prdata = APB_DATA_W'(cfg_reg.green_gain);
            REG_RED_BLUE_GAIN:  prdata = APB_DATA_W'(cfg_reg.red_blue_gain);
            REG_MIN_BLOB_AREA:  prdata = APB_DATA_W'(cfg_reg.min_blob_area);
            REG_DISTANCE_RATIO: prdata = APB_DATA_W'(cfg_reg.distance_ratio);
            default:            prdata = '0;
        endcase
    end

    assign s_tready = !q_full;
    assign accept   = s_tvalid && s_tready;

    cbc_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .accept    (accept),
        .red       (s_tdata[7:0]),
        .green     (s_tdata[15:8]),
        .blue      (s_tdata[23:16]),
        .line_end  (s_tuser),
        .frame_end (s_tlast),
        .item      (push_item)
    );

    cbc_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (accept),
        .push_item (push_item),
        .pop       (q_pop),
        .head      (head),
        .full      (q_full),
        .empty     (q_empty)
    );

    cbc_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .head     (head),
        .empty    (q_empty),
        .pop      (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
    import cbc_pkg::*;

    localparam int QUIET_LIMIT = 2000;
    localparam int LONG_HOLD   = 200;
    localparam int END_SETTLE  = 40;
    localparam int PRINT_CAP   = 100;

    localparam logic [REG_IDX_W-1:0] REG_SPARE_LOW  = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_SPARE_HIGH = 3'd7;

    typedef struct {
        logic [PIX_W-1:0] red;
        logic [PIX_W-1:0] green;
        logic [PIX_W-1:0] blue;
        logic             line_end;
        logic             frame_end;
        logic             drain_first;
    } pixel_item_t;

    typedef struct {
        logic               mask;
        logic               frame_done;
        logic               found;
        logic [CX_W-1:0]    centre_x;
        logic [CX_W-1:0]    centre_y;
        logic [WIDTH_W-1:0] blob_width;
        logic [AREA_W-1:0]  blob_area;
        logic [RATIO_W-1:0] distance;
    } pixel_result_t;

    typedef struct packed {
        logic [5:0]         pad;
        logic [RATIO_W-1:0] distance;
        logic [AREA_W-1:0]  blob_area;
        logic [WIDTH_W-1:0] blob_width;
        logic [CX_W-1:0]    centre_y;
        logic [CX_W-1:0]    centre_x;
        logic               found;
        logic               mask;
    } out_word_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   psel = 1'b0;
    logic                   penable = 1'b0;
    logic                   pwrite = 1'b0;
    logic [APB_ADDR_W-1:0]  paddr = '0;
    logic [APB_DATA_W-1:0]  pwdata = '0;
    logic [APB_DATA_W-1:0]  prdata;
    logic                   pready;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [TDATA_IN_W-1:0]  s_tdata = '0;   // red, green, blue
    logic                   s_tuser = 1'b0; // line_end
    logic                   s_tlast = 1'b0; // frame_end
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [TDATA_OUT_W-1:0] m_tdata;        // mask, found, centre_x, centre_y, blob_width,
                                            // blob_area, distance, zero pad
    logic                   m_tlast;        // frame_done

    color_blob_centroid_core DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    // register copies
    logic [FLOOR_W-1:0] floor_cfg   = GREEN_FLOOR_RESET;
    logic [GAIN_W-1:0]  g_gain_cfg  = GREEN_GAIN_RESET;
    logic [GAIN_W-1:0]  rb_gain_cfg = RED_BLUE_GAIN_RESET;
    logic [AREA_W-1:0]  area_cfg    = MIN_BLOB_AREA_RESET;
    logic [RATIO_W-1:0] ratio_cfg   = DISTANCE_RATIO_RESET;

    // frame accumulators
    int unsigned     col_pos = 0;
    int unsigned     row_pos = 0;
    int unsigned     green_count = 0;
    int unsigned     run_len = 0;
    int unsigned     widest_run = 0;
    longint unsigned x_sum = 0;
    longint unsigned y_sum = 0;

    pixel_item_t   pending_pixels[$];
    pixel_result_t due_results[$];

    logic pix_taken = 1'b0;
    bit   send_idle_on = 1'b0;
    bit   recv_idle_on = 1'b0;
    int   holds_asked = 0;
    int   mismatches = 0;
    int   pixels_queued = 0;
    int   pixels_taken = 0;
    int   results_seen = 0;
    int   frames_reported = 0;
    int   blobs_reported = 0;
    int   settings_used = 0;
    int   widest_reported = 0;

    initial
    begin
        forever #2 clk = ~clk;
    end

    task automatic report_mismatch(input string msg);
        if (mismatches < PRINT_CAP)
        begin
            $display("%0t mismatch: %s", $time, msg);
        end
        mismatches++;
    endtask

    task automatic check_field(input string name, input logic [31:0] got_v,
                               input logic [31:0] want_v);
        if (got_v !== want_v)
        begin
            report_mismatch($sformatf("result %0d %s: got %0d, want %0d",
                                      results_seen, name, got_v, want_v));
        end
    endtask

    function automatic pixel_result_t score_pixel(input logic [PIX_W-1:0] r,
                                                  input logic [PIX_W-1:0] g,
                                                  input logic [PIX_W-1:0] b,
                                                  input logic le, input logic fe);
        pixel_result_t res;
        logic          hit;
        res.mask       = 1'b0;
        res.frame_done = 1'b0;
        res.found      = 1'b0;
        res.centre_x   = '0;
        res.centre_y   = '0;
        res.blob_width = '0;
        res.blob_area  = '0;
        res.distance   = '0;
        hit = (int'(g_gain_cfg) * int'(g) > int'(rb_gain_cfg) * (int'(r) + int'(b)))
              && (g > floor_cfg);
        res.mask = hit;
        if (hit)
        begin
            if (green_count < COUNT_CAP)
            begin
                green_count++;
                x_sum += col_pos;
                y_sum += row_pos;
            end
            if (run_len < MAX_WIDTH)
            begin
                run_len++;
            end
            if (run_len > widest_run)
            begin
                widest_run = run_len;
            end
        end
        else
        begin
            run_len = 0;
        end
        if (fe)
        begin
            res.frame_done = 1'b1;
            res.found      = green_count > area_cfg;
            res.blob_width = widest_run[WIDTH_W-1:0];
            res.blob_area  = green_count[AREA_W-1:0];
            if (res.found && green_count != 0)
            begin
                res.centre_x = CX_W'(x_sum / green_count);
                res.centre_y = CX_W'(y_sum / green_count);
                if (widest_run != 0)
                begin
                    res.distance = RATIO_W'(ratio_cfg / widest_run);
                end
            end
            col_pos     = 0;
            row_pos     = 0;
            green_count = 0;
            x_sum       = 0;
            y_sum       = 0;
            run_len     = 0;
            widest_run  = 0;
        end
        else if (le)
        begin
            col_pos = 0;
            run_len = 0;
            if (row_pos < MAX_HEIGHT - 1)
            begin
                row_pos++;
            end
        end
        else if (col_pos < MAX_WIDTH - 1)
        begin
            col_pos++;
        end
        return res;
    endfunction

    // driver
    always @(negedge clk)
    begin
        pixel_item_t nxt;
        int          gap_left;
        if (!s_tvalid || pix_taken)
        begin
            if (gap_left > 0)
            begin
                gap_left--;
                s_tvalid <= 1'b0;
            end
            else if (pending_pixels.size() != 0 &&
                     !(pending_pixels[0].drain_first && due_results.size() != 0))
            begin
                nxt = pending_pixels.pop_front();
                s_tdata  <= {nxt.blue, nxt.green, nxt.red};
                s_tuser  <= nxt.line_end;
                s_tlast  <= nxt.frame_end;
                s_tvalid <= 1'b1;
                if (send_idle_on && $urandom_range(0, 11) == 0)
                begin
                    gap_left = $urandom_range(1, 13);
                end
            end
            else
            begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // receiver
    always @(negedge clk)
    begin
        int stall_left;
        int holds_done;
        if (stall_left > 0)
        begin
            stall_left--;
            m_tready <= 1'b0;
        end
        else if (holds_done != holds_asked)
        begin
            holds_done++;
            stall_left = LONG_HOLD - 1;
            m_tready <= 1'b0;
        end
        else if (recv_idle_on && $urandom_range(0, 9) == 0)
        begin
            stall_left = $urandom_range(0, 12);
            m_tready <= 1'b0;
        end
        else
        begin
            m_tready <= 1'b1;
        end
    end

    // monitor
    always @(posedge clk)
    begin
        pixel_result_t want;
        out_word_t     got;
        pix_taken <= s_tvalid && s_tready;
        if (rst_n && s_tvalid && s_tready)
        begin
            due_results.push_back(score_pixel(s_tdata[7:0], s_tdata[15:8], s_tdata[23:16],
                                              s_tuser, s_tlast));
            pixels_taken++;
        end
        if (rst_n && m_tvalid && m_tready)
        begin
            got = out_word_t'(m_tdata);
            if (due_results.size() == 0)
            begin
                report_mismatch("result with nothing outstanding");
            end
            else
            begin
                want = due_results.pop_front();
                check_field("mask", got.mask, want.mask);
                check_field("frame_done", m_tlast, want.frame_done);
                check_field("found", got.found, want.found);
                check_field("centre_x", got.centre_x, want.centre_x);
                check_field("centre_y", got.centre_y, want.centre_y);
                check_field("blob_width", got.blob_width, want.blob_width);
                check_field("blob_area", got.blob_area, want.blob_area);
                check_field("distance", got.distance, want.distance);
                if (want.frame_done)
                begin
                    frames_reported++;
                end
                if (want.found)
                begin
                    blobs_reported++;
                end
                if (int'(want.blob_width) > widest_reported)
                begin
                    widest_reported = int'(want.blob_width);
                end
            end
            results_seen++;
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        int quiet;
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || psel || !rst_n)
        begin
            quiet = 0;
        end
        else
        begin
            quiet++;
        end
        if (quiet >= QUIET_LIMIT)
        begin
            $display("watchdog: no transaction for %0d cycles", quiet);
            $display("end of test: mismatches");
            $finish;
        end
    end

    task automatic add_pixel(input logic [PIX_W-1:0] r, input logic [PIX_W-1:0] g,
                             input logic [PIX_W-1:0] b, input logic le, input logic fe,
                             input logic drain);
        pixel_item_t p;
        p.red         = r;
        p.green       = g;
        p.blue        = b;
        p.line_end    = le;
        p.frame_end   = fe;
        p.drain_first = drain;
        pending_pixels.push_back(p);
        pixels_queued++;
    endtask

    task automatic apb_write(input logic [REG_IDX_W-1:0] idx, input logic [31:0] val);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_GREEN_FLOOR:    floor_cfg   = val[FLOOR_W-1:0];
            REG_GREEN_GAIN:     g_gain_cfg  = val[GAIN_W-1:0];
            REG_RED_BLUE_GAIN:  rb_gain_cfg = val[GAIN_W-1:0];
            REG_MIN_BLOB_AREA:  area_cfg    = val[AREA_W-1:0];
            REG_DISTANCE_RATIO: ratio_cfg   = val[RATIO_W-1:0];
            default: ;
        endcase
    endtask

    task automatic apb_check(input logic [REG_IDX_W-1:0] idx, input logic [31:0] want_v);
        logic [31:0] rd;
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {idx, 2'b00};
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        rd = prdata;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (rd !== want_v)
        begin
            report_mismatch($sformatf("register %0d read %0h, want %0h", idx, rd, want_v));
        end
    endtask

    task automatic verify_regs();
        apb_check(REG_GREEN_FLOOR, 32'(floor_cfg));
        apb_check(REG_GREEN_GAIN, 32'(g_gain_cfg));
        apb_check(REG_RED_BLUE_GAIN, 32'(rb_gain_cfg));
        apb_check(REG_MIN_BLOB_AREA, 32'(area_cfg));
        apb_check(REG_DISTANCE_RATIO, 32'(ratio_cfg));
    endtask

    task automatic program_regs(input int unsigned fl, input int unsigned gg,
                                input int unsigned rbg, input int unsigned area,
                                input int unsigned ratio);
        apb_write(REG_GREEN_FLOOR, fl);
        apb_write(REG_GREEN_GAIN, gg);
        apb_write(REG_RED_BLUE_GAIN, rbg);
        apb_write(REG_MIN_BLOB_AREA, area);
        apb_write(REG_DISTANCE_RATIO, ratio);
        verify_regs();
        settings_used++;
    endtask

    task automatic settle();
        while (pending_pixels.size() != 0 || s_tvalid || due_results.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    task automatic queue_blob_frame(input int rows, input int cols);
        int   x0, x1, y0, y1, len, r, c;
        bit   in_box, row_last, frame_last;
        logic [PIX_W-1:0] rr, gg, bb;
        x0 = $urandom_range(0, cols - 1);
        x1 = $urandom_range(x0, cols - 1);
        y0 = $urandom_range(0, rows - 1);
        y1 = $urandom_range(y0, rows - 1);
        for (r = 0; r < rows; r++)
        begin
            len = ($urandom_range(0, 4) == 0) ? $urandom_range(1, cols) : cols;
            for (c = 0; c < len; c++)
            begin
                in_box = c >= x0 && c <= x1 && r >= y0 && r <= y1;
                if ($urandom_range(0, 9) < (in_box ? 9 : 1))
                begin
                    rr = PIX_W'($urandom_range(0, 70));
                    gg = PIX_W'($urandom_range(140, 255));
                    bb = PIX_W'($urandom_range(0, 70));
                end
                else
                begin
                    rr = PIX_W'($urandom_range(0, 255));
                    gg = PIX_W'($urandom_range(0, 255));
                    bb = PIX_W'($urandom_range(0, 255));
                end
                row_last   = c == len - 1;
                frame_last = row_last && r == rows - 1;
                add_pixel(rr, gg, bb, frame_last ? 1'($urandom_range(0, 1)) : row_last,
                          frame_last, 1'b0);
            end
        end
    endtask

    task automatic queue_noise_frame(input int len);
        int i;
        for (i = 0; i < len; i++)
        begin
            add_pixel(PIX_W'($urandom_range(0, 255)), PIX_W'($urandom_range(0, 255)),
                      PIX_W'($urandom_range(0, 255)),
                      $urandom_range(0, 4) == 0, i == len - 1, 1'b0);
        end
    endtask

    task automatic queue_random_items(input int target);
        int stop_at;
        stop_at = pixels_queued + target;
        while (pixels_queued < stop_at)
        begin
            if ($urandom_range(0, 4) == 0)
            begin
                queue_noise_frame($urandom_range(1, 30));
            end
            else if ($urandom_range(0, 14) == 0)
            begin
                queue_blob_frame($urandom_range(3, 6), $urandom_range(12, 24));
            end
            else
            begin
                queue_blob_frame($urandom_range(1, 8), $urandom_range(1, 16));
            end
        end
    endtask

    task automatic random_config();
        int unsigned fl, gg, area;
        fl   = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(60, 200);
        gg   = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 15);
        area = ($urandom_range(0, 7) == 0) ? $urandom_range(0, COUNT_CAP)
                                           : $urandom_range(0, 25);
        program_regs(fl, gg, $urandom_range(0, 15), area, $urandom_range(0, 1048575));
    endtask

    initial
    begin
        int i, ph;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // defaults after reset
        verify_regs();
        add_pixel(8'd0, 8'd0, 8'd0, 1'b0, 1'b0, 1'b0);
        add_pixel(8'd255, 8'd255, 8'd255, 1'b0, 1'b0, 1'b0);
        add_pixel(8'd0, 8'd255, 8'd0, 1'b0, 1'b0, 1'b0);
        add_pixel(8'd255, 8'd0, 8'd255, 1'b0, 1'b0, 1'b0);
        add_pixel(8'd0, 8'd128, 8'd0, 1'b0, 1'b0, 1'b0);
        add_pixel(8'd0, 8'd129, 8'd0, 1'b0, 1'b0, 1'b0);
        add_pixel(8'd102, 8'd153, 8'd102, 1'b0, 1'b0, 1'b0);
        add_pixel(8'd101, 8'd153, 8'd102, 1'b1, 1'b0, 1'b0);
        add_pixel(8'hAA, 8'h55, 8'hAA, 1'b0, 1'b0, 1'b0);
        add_pixel(8'h55, 8'hAA, 8'h55, 1'b0, 1'b0, 1'b0);
        add_pixel(8'd0, 8'd200, 8'd0, 1'b0, 1'b1, 1'b0);
        add_pixel(8'd0, 8'd0, 8'd0, 1'b1, 1'b1, 1'b0);
        settle();

        // loosest settings: any green marks, every blob counts
        program_regs(0, 15, 0, 0, 1048575);
        add_pixel(8'd0, 8'd1, 8'd0, 1'b1, 1'b1, 1'b0);
        add_pixel(8'd0, 8'd0, 8'd0, 1'b0, 1'b1, 1'b0);
        add_pixel(8'd255, 8'd1, 8'd255, 1'b0, 1'b0, 1'b0);
        add_pixel(8'd0, 8'd0, 8'd0, 1'b0, 1'b0, 1'b0);
        add_pixel(8'd0, 8'd9, 8'd0, 1'b1, 1'b0, 1'b0);
        add_pixel(8'd0, 8'd0, 8'd0, 1'b0, 1'b0, 1'b0);
        add_pixel(8'd0, 8'd7, 8'd0, 1'b0, 1'b0, 1'b0);
        add_pixel(8'd0, 8'd255, 8'd0, 1'b1, 1'b1, 1'b0);
        settle();

        // strictest settings: nothing marks
        program_regs(255, 0, 15, COUNT_CAP, 0);
        queue_random_items(15);
        settle();

        // long receiver hold while the sender keeps offering
        program_regs(100, 4, 3, 10, 41489);
        send_idle_on = 1'b0;
        recv_idle_on = 1'b0;
        holds_asked++;
        for (i = 0; i < 40; i++)
        begin
            add_pixel(8'd10, 8'd200, 8'd10, i == 39, 1'b0, 1'b0);
        end
        add_pixel(8'd10, 8'd200, 8'd10, 1'b0, 1'b0, 1'b0);
        add_pixel(8'd0, 8'd0, 8'd0, 1'b0, 1'b0, 1'b0);
        add_pixel(8'd10, 8'd200, 8'd10, 1'b0, 1'b1, 1'b0);
        for (i = 0; i < 12; i++)
        begin
            add_pixel(8'd10, 8'd200, 8'd10, 1'b1, i == 11, i == 0);
        end
        settle();

        // writes to unused addresses leave the registers alone
        apb_write(REG_SPARE_LOW, 32'hFFFF_FFFF);
        apb_write(REG_SPARE_HIGH, 32'h0000_0000);
        verify_regs();

        for (ph = 0; ph < 5; ph++)
        begin
            random_config();
            send_idle_on = $urandom_range(0, 3) != 0;
            recv_idle_on = $urandom_range(0, 3) != 0;
            queue_random_items(20);
            if (ph == 2)
            begin
                holds_asked++;
                add_pixel(8'd0, 8'd255, 8'd0, 1'b1, 1'b1, 1'b1);
            end
            queue_random_items(20);
            settle();
        end

        random_config();
        send_idle_on = 1'b0;
        recv_idle_on = 1'b0;
        queue_random_items(40);
        settle();

        repeat (END_SETTLE) @(posedge clk);
        if (due_results.size() != 0)
        begin
            report_mismatch($sformatf("%0d results never arrived", due_results.size()));
        end

        $display("run: %0d pixels over %0d frames, %0d blobs found, %0d register settings",
                 pixels_taken, frames_reported, blobs_reported, settings_used);
        $display("run: widest reported run %0d, long receiver holds and drained pauses included",
                 widest_reported);
        if (mismatches == 0)
        begin
            $display("end of test: clean");
        end
        else
        begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
